@@ hdl/tcsp_pkg.sv @@
package tcsp_pkg;

    localparam int OP_W     = 3;
    localparam int ID_W     = 4;
    localparam int COUNT_W  = 4;
    localparam int INDEX_W  = 3;
    localparam int TIME_W   = 32;
    localparam int SOUND_W  = 16;
    localparam int STATUS_W = 2;

    // most sound items that one tick may give
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [OP_W-1:0] OP_DEFINE  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
    localparam logic [OP_W-1:0] OP_TRIGGER = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SOUND  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  delay;
        logic [SOUND_W-1:0] sound;
    } step_t;

endpackage

@@ hdl/tcsp_cmd_if.sv @@
interface tcsp_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tcsp_pkg::OP_W-1:0]     operation;
    logic [tcsp_pkg::ID_W-1:0]     sequence_id;
    logic [tcsp_pkg::COUNT_W-1:0]  step_count;
    logic [tcsp_pkg::INDEX_W-1:0]  step_index;
    logic [tcsp_pkg::TIME_W-1:0]   step_delay;
    logic [tcsp_pkg::SOUND_W-1:0]  sound_id;
    logic signed [tcsp_pkg::TIME_W-1:0] delta_time;

    modport source (output valid, operation, sequence_id, step_count, step_index,
                    step_delay, sound_id, delta_time, input ready);
    modport sink   (input valid, operation, sequence_id, step_count, step_index,
                    step_delay, sound_id, delta_time, output ready);
endinterface

@@ hdl/tcsp_rsp_if.sv @@
interface tcsp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [tcsp_pkg::STATUS_W-1:0] status;
    logic [tcsp_pkg::SOUND_W-1:0]  played_sound;
    logic                          last;

    modport source (output valid, kind, status, played_sound, last, input ready);
    modport sink   (input valid, kind, status, played_sound, last, output ready);
endinterface

@@ hdl/tcsp_step_store.sv @@
module tcsp_step_store #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tcsp_pkg::step_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tcsp_pkg::step_t     rd_data
);

    tcsp_pkg::step_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/timed_cue_sequence_player.sv @@
// Timed cue sequence player. Commands arrive as items on cmd: define a sequence
// (step count), write one step (delay after trigger in unsigned 16.16 seconds and
// a sound id), trigger a sequence, tick (signed 16.16 advance, negatives count as
// zero) and clear. Every command but tick returns one status item. A tick returns
// one item per sound played, the final one marked last, or a single ok status if
// nothing plays. Steps live in a simple dual-port synchronous step memory, running
// instances in a small active memory that the tick reads, updates and writes back
// in place, compacting finished instances out. A non-tick command returns its
// status item on the cycle after it is accepted, and the next command can be taken
// on that same cycle while rsp is ready, so such commands can run one per cycle.
// A tick holds cmd off until its final item is loaded: for every active instance
// it reads, updates and writes back the entry, walking its due steps one at a
// time in between, with one more look when the walk stops on a step that is not
// yet due, and ends with the final flush. The step memory gives one read per
// cycle. The walk also stalls while rsp has not taken earlier sound items.
module timed_cue_sequence_player #(
    parameter int MAX_SEQUENCES = 16,
    parameter int MAX_STEPS     = 8,
    parameter int MAX_ACTIVE    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    tcsp_cmd_if.sink    cmd,
    tcsp_rsp_if.source  rsp
);

    localparam int SEQ_W  = $clog2(MAX_SEQUENCES);
    localparam int NXT_W  = $clog2(MAX_STEPS + 1);
    localparam int DEPTH  = MAX_SEQUENCES * MAX_STEPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AI_W   = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CNT_W  = $clog2(MAX_ACTIVE + 1);
    localparam int TW     = tcsp_pkg::TIME_W;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [NXT_W-1:0] next;
        logic [TW-1:0]    elapsed;
    } act_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_ACT,
        S_ACT,
        S_STEP,
        S_WB,
        S_FLUSH
    } state_t;

    state_t state_reg;

    // sequence table: defined flags reset, lengths written before use
    logic                     defined_reg [MAX_SEQUENCES];
    logic [NXT_W-1:0]         len_reg     [MAX_SEQUENCES];

    // active instance memory
    act_entry_t               act_mem [MAX_ACTIVE];
    act_entry_t               act_rd;
    logic                     act_wr_en;
    logic [AI_W-1:0]          act_wr_addr;
    act_entry_t               act_wr_data;
    logic                     act_rd_en;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [CNT_W-1:0]         w_reg;
    logic [TW-1:0]            dt_reg;
    logic [tcsp_pkg::RES_W-1:0] n_reg;

    // instance being walked
    logic [SEQ_W-1:0]         cur_seq_reg;
    logic [NXT_W-1:0]         cur_next_reg;
    logic [NXT_W-1:0]         cur_len_reg;
    logic [TW-1:0]            cur_e_reg;

    // the newest sound is held back until we know whether it is the last
    logic                     pend_valid_reg;
    logic [tcsp_pkg::SOUND_W-1:0] pend_sound_reg;

    logic                     out_valid_reg;
    logic                     out_kind_reg;
    logic [tcsp_pkg::STATUS_W-1:0] out_status_reg;
    logic [tcsp_pkg::SOUND_W-1:0]  out_sound_reg;
    logic                     out_last_reg;

    // step memory port
    logic                     step_wr_en;
    logic [ADDR_W-1:0]        step_wr_addr;
    tcsp_pkg::step_t          step_wr_data;
    logic                     step_rd_en;
    logic [ADDR_W-1:0]        step_rd_addr;
    tcsp_pkg::step_t          step_rd;

    logic                     out_free;
    logic                     out_load;
    logic                     accept;
    logic                     id_ok;
    logic [SEQ_W-1:0]         cmd_seq;
    logic [TW-1:0]            dt_clamped;
    logic [TW:0]              e_sum;
    logic [TW-1:0]            e_sat;
    logic [NXT_W-1:0]         act_len;
    logic                     step_hit;
    logic                     emit_req;
    logic                     step_stall;
    logic [NXT_W-1:0]         nxt1;
    logic                     keep;
    logic [tcsp_pkg::STATUS_W-1:0] cmd_status;
    logic [NXT_W-1:0]         sat_count;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign cmd.ready  = (state_reg == S_IDLE) && out_free;
    assign accept     = cmd.valid && cmd.ready;
    assign cmd_seq    = SEQ_W'(cmd.sequence_id);
    assign id_ok      = (cmd.sequence_id != '0) && (int'(cmd.sequence_id) < MAX_SEQUENCES);
    assign dt_clamped = cmd.delta_time[TW-1] ? '0 : TW'(cmd.delta_time);
    assign sat_count  = (int'(cmd.step_count) > MAX_STEPS) ? NXT_W'(MAX_STEPS)
                                                          : NXT_W'(cmd.step_count);

    // saturating elapsed-time update
    assign e_sum    = {1'b0, act_rd.elapsed} + {1'b0, dt_reg};
    assign e_sat    = e_sum[TW] ? '1 : e_sum[TW-1:0];
    assign act_len  = len_reg[act_rd.seq];

    assign step_hit   = cur_e_reg >= step_rd.delay;
    assign emit_req   = (step_rd.sound != '0) && (int'(n_reg) < tcsp_pkg::MAX_RESULTS);
    assign step_stall = (state_reg == S_STEP) && step_hit && emit_req
                        && pend_valid_reg && !out_free;
    assign nxt1       = cur_next_reg + NXT_W'(1);
    assign keep       = cur_next_reg < cur_len_reg;

    // load the output register with a status, a held sound or the final item
    assign out_load = ((state_reg == S_IDLE) && accept
                       && (cmd.operation != tcsp_pkg::OP_TICK))
                      || ((state_reg == S_STEP) && step_hit && !step_stall
                          && emit_req && pend_valid_reg)
                      || ((state_reg == S_FLUSH) && out_free);

    always_comb
    begin
        cmd_status = tcsp_pkg::ST_OK;
        case (cmd.operation)
            tcsp_pkg::OP_DEFINE:
            begin
                if (!id_ok)
                    cmd_status = tcsp_pkg::ST_REJECT;
            end
            tcsp_pkg::OP_WRITE:
            begin
                if (!id_ok || int'(cmd.step_index) >= MAX_STEPS)
                    cmd_status = tcsp_pkg::ST_REJECT;
            end
            tcsp_pkg::OP_TRIGGER:
            begin
                if (!id_ok || !defined_reg[cmd_seq])
                    cmd_status = tcsp_pkg::ST_REJECT;
                else if (int'(count_reg) >= MAX_ACTIVE)
                    cmd_status = tcsp_pkg::ST_FULL;
            end
            tcsp_pkg::OP_TICK,
            tcsp_pkg::OP_CLEAR:
            begin
                cmd_status = tcsp_pkg::ST_OK;
            end
            default:
            begin
                cmd_status = tcsp_pkg::ST_REJECT;
            end
        endcase
    end

    // step memory write and read addressing
    always_comb
    begin
        step_wr_en   = accept && (cmd.operation == tcsp_pkg::OP_WRITE)
                       && (cmd_status == tcsp_pkg::ST_OK);
        step_wr_addr = ADDR_W'(int'(cmd_seq) * MAX_STEPS + int'(cmd.step_index));
        step_wr_data = '{delay: cmd.step_delay, sound: cmd.sound_id};

        step_rd_en   = 1'b0;
        step_rd_addr = ADDR_W'(int'(cur_seq_reg) * MAX_STEPS + int'(nxt1));
        case (state_reg)
            S_ACT:
            begin
                step_rd_en   = act_rd.next < act_len;
                step_rd_addr = ADDR_W'(int'(act_rd.seq) * MAX_STEPS + int'(act_rd.next));
            end
            S_STEP:
            begin
                step_rd_en = step_hit && !step_stall && (nxt1 < cur_len_reg);
            end
            default:
            begin
                step_rd_en = 1'b0;
            end
        endcase
    end

    // active memory: trigger appends, write-back compacts into slot w
    always_comb
    begin
        act_rd_en   = state_reg == S_RD_ACT;
        act_wr_en   = 1'b0;
        act_wr_addr = w_reg[AI_W-1:0];
        act_wr_data = '{seq: cur_seq_reg, next: cur_next_reg, elapsed: cur_e_reg};
        if (accept && cmd.operation == tcsp_pkg::OP_TRIGGER
            && cmd_status == tcsp_pkg::ST_OK)
        begin
            act_wr_en   = 1'b1;
            act_wr_addr = count_reg[AI_W-1:0];
            act_wr_data = '{seq: cmd_seq, next: '0, elapsed: '0};
        end
        else if (state_reg == S_WB && keep)
        begin
            act_wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_wr_en)
        begin
            act_mem[act_wr_addr] <= act_wr_data;
        end
        if (act_rd_en)
        begin
            act_rd <= act_mem[i_reg[AI_W-1:0]];
        end
    end

    tcsp_step_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_step_store (
        .clk     (clk),
        .wr_en   (step_wr_en),
        .wr_addr (step_wr_addr),
        .wr_data (step_wr_data),
        .rd_en   (step_rd_en),
        .rd_addr (step_rd_addr),
        .rd_data (step_rd)
    );

    // sequence lengths need no reset
    always_ff @(posedge clk)
    begin
        if (accept && cmd.operation == tcsp_pkg::OP_DEFINE && id_ok)
        begin
            len_reg[cmd_seq] <= sat_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int k = 0; k < MAX_SEQUENCES; k++)
            begin
                defined_reg[k] <= 1'b0;
            end
            count_reg      <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.operation == tcsp_pkg::OP_TICK)
                        begin
                            dt_reg         <= dt_clamped;
                            i_reg          <= '0;
                            w_reg          <= '0;
                            n_reg          <= '0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= (count_reg == '0) ? S_FLUSH : S_RD_ACT;
                        end
                        else
                        begin
                            if (cmd.operation == tcsp_pkg::OP_DEFINE && id_ok)
                                defined_reg[cmd_seq] <= 1'b1;
                            if (cmd.operation == tcsp_pkg::OP_TRIGGER
                                && cmd_status == tcsp_pkg::ST_OK)
                                count_reg <= count_reg + CNT_W'(1);
                            if (cmd.operation == tcsp_pkg::OP_CLEAR)
                                count_reg <= '0;
                            out_kind_reg   <= tcsp_pkg::KIND_STATUS;
                            out_status_reg <= cmd_status;
                            out_sound_reg  <= '0;
                            out_last_reg   <= 1'b1;
                        end
                    end
                end
                S_RD_ACT:
                begin
                    state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    cur_seq_reg  <= act_rd.seq;
                    cur_next_reg <= act_rd.next;
                    cur_len_reg  <= act_len;
                    cur_e_reg    <= e_sat;
                    state_reg    <= (act_rd.next < act_len) ? S_STEP : S_WB;
                end
                S_STEP:
                begin
                    if (!step_hit)
                    begin
                        state_reg <= S_WB;
                    end
                    else if (!step_stall)
                    begin
                        if (emit_req)
                        begin
                            // push the held sound out, hold the new one
                            if (pend_valid_reg)
                            begin
                                out_kind_reg   <= tcsp_pkg::KIND_SOUND;
                                out_status_reg <= tcsp_pkg::ST_OK;
                                out_sound_reg  <= pend_sound_reg;
                                out_last_reg   <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_sound_reg <= step_rd.sound;
                            n_reg          <= n_reg + tcsp_pkg::RES_W'(1);
                        end
                        cur_next_reg <= nxt1;
                        if (nxt1 >= cur_len_reg)
                            state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (keep)
                        w_reg <= w_reg + CNT_W'(1);
                    i_reg <= i_reg + CNT_W'(1);
                    if (int'(i_reg) + 1 < int'(count_reg))
                    begin
                        state_reg <= S_RD_ACT;
                    end
                    else
                    begin
                        count_reg <= keep ? w_reg + CNT_W'(1) : w_reg;
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_kind_reg   <= pend_valid_reg ? tcsp_pkg::KIND_SOUND
                                                         : tcsp_pkg::KIND_STATUS;
                        out_status_reg <= tcsp_pkg::ST_OK;
                        out_sound_reg  <= pend_valid_reg ? pend_sound_reg : '0;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = out_kind_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.played_sound = out_sound_reg;
    assign rsp.last         = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_ACTIVE)
        else $error("active count beyond capacity");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (w_reg <= i_reg))
        else $error("compaction write slot ahead of read slot");

    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (n_reg != '0))
        else $error("held sound without a counted result");

    a_sound_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == tcsp_pkg::KIND_SOUND)
        |-> (out_status_reg == tcsp_pkg::ST_OK))
        else $error("sound item with nonzero status");

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SEQ    = 16;
    localparam int N_STEPS  = 8;
    localparam int N_ACTIVE = 8;
    localparam int CYCLE_LIMIT = 400000;

    // one expected response item
    typedef struct packed {
        logic                          kind;
        logic [tcsp_pkg::STATUS_W-1:0] status;
        logic [tcsp_pkg::SOUND_W-1:0]  sound;
        logic                          last;
    } cue_rsp_t;

    // one command item, plus an optional hand-typed expectation
    typedef struct {
        logic [tcsp_pkg::OP_W-1:0]     op;
        logic [tcsp_pkg::ID_W-1:0]     id;
        logic [tcsp_pkg::COUNT_W-1:0]  cnt;
        logic [tcsp_pkg::INDEX_W-1:0]  idx;
        logic [tcsp_pkg::TIME_W-1:0]   delay;
        logic [tcsp_pkg::SOUND_W-1:0]  snd;
        logic [tcsp_pkg::TIME_W-1:0]   delta;
        bit                            typed;
        logic [tcsp_pkg::STATUS_W-1:0] typed_status;
    } cue_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    tcsp_cmd_if cmd ();
    tcsp_rsp_if rsp ();

    timed_cue_sequence_player dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    // shadow copy of the cue tables and the active list
    bit                           seq_defined [N_SEQ];
    logic [3:0]                   seq_len     [N_SEQ];
    logic [tcsp_pkg::TIME_W-1:0]  step_time   [N_SEQ*N_STEPS];
    logic [tcsp_pkg::SOUND_W-1:0] step_sound  [N_SEQ*N_STEPS];
    logic [3:0]                   act_seq     [N_ACTIVE];
    logic [3:0]                   act_next    [N_ACTIVE];
    logic [tcsp_pkg::TIME_W-1:0]  act_elapsed [N_ACTIVE];
    int                           act_count;

    cue_rsp_t pending_rsp[$];
    int       errors;
    int       cycles;
    bit       quiet;       // no idling on either side

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic add_rsp(input cue_rsp_t r);
        pending_rsp = {pending_rsp, r};
    endtask

    function automatic cue_rsp_t status_item(input logic [tcsp_pkg::STATUS_W-1:0] st);
        cue_rsp_t r;
        r.kind = tcsp_pkg::KIND_STATUS;
        r.status = st;
        r.sound = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // compute the response items of one command and advance the shadow state
    task automatic predict_cue(input cue_cmd_t c);
        logic [tcsp_pkg::STATUS_W-1:0] st;
        logic [tcsp_pkg::TIME_W-1:0] dt, e;
        int n, w, s, sq;
        cue_rsp_t r;
        st = tcsp_pkg::ST_OK;
        n = 0;
        w = 0;
        case (c.op)
            tcsp_pkg::OP_DEFINE:
                if (c.id == 0) st = tcsp_pkg::ST_REJECT;
                else
                begin
                    seq_defined[c.id] = 1'b1;
                    seq_len[c.id] = (c.cnt > N_STEPS) ? 4'(N_STEPS) : c.cnt;
                end
            tcsp_pkg::OP_WRITE:
                if (c.id == 0) st = tcsp_pkg::ST_REJECT;
                else
                begin
                    step_time[c.id*N_STEPS+c.idx] = c.delay;
                    step_sound[c.id*N_STEPS+c.idx] = c.snd;
                end
            tcsp_pkg::OP_TRIGGER:
                if (c.id == 0 || !seq_defined[c.id]) st = tcsp_pkg::ST_REJECT;
                else if (act_count >= N_ACTIVE) st = tcsp_pkg::ST_FULL;
                else
                begin
                    act_seq[act_count] = c.id;
                    act_next[act_count] = '0;
                    act_elapsed[act_count] = '0;
                    act_count++;
                end
            tcsp_pkg::OP_TICK:
            begin
                dt = c.delta[31] ? '0 : c.delta;
                for (int i = 0; i < act_count; i++)
                begin
                    sq = act_seq[i];
                    e = act_elapsed[i];
                    e = (e > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF : e + dt;
                    act_elapsed[i] = e;
                    while (act_next[i] < seq_len[sq])
                    begin
                        s = sq * N_STEPS + act_next[i];
                        if (e < step_time[s]) break;
                        if (step_sound[s] != 0 && n < tcsp_pkg::MAX_RESULTS)
                        begin
                            r.kind = tcsp_pkg::KIND_SOUND;
                            r.status = tcsp_pkg::ST_OK;
                            r.sound = step_sound[s];
                            r.last = 1'b0;
                            add_rsp(r);
                            n++;
                        end
                        act_next[i]++;
                    end
                end
                for (int i = 0; i < act_count; i++)
                begin
                    if (act_next[i] >= seq_len[act_seq[i]]) continue;
                    act_seq[w] = act_seq[i];
                    act_next[w] = act_next[i];
                    act_elapsed[w] = act_elapsed[i];
                    w++;
                end
                act_count = w;
                if (n > 0) pending_rsp[$].last = 1'b1;
            end
            tcsp_pkg::OP_CLEAR: act_count = 0;
            default: st = tcsp_pkg::ST_REJECT;
        endcase
        if (c.op != tcsp_pkg::OP_TICK || n == 0)
        begin
            if (c.typed && st != c.typed_status)
                report($sformatf("predictor status %0d vs table %0d", st, c.typed_status));
            add_rsp(status_item(st));
        end
    endtask

    // drive one command item and wait for it to be taken; valid stays high after
    task automatic send_cue(input cue_cmd_t c);
        while (!quiet && $urandom_range(99) < 16)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        predict_cue(c);
        cmd.valid       <= 1'b1;
        cmd.operation   <= c.op;
        cmd.sequence_id <= c.id;
        cmd.step_count  <= c.cnt;
        cmd.step_index  <= c.idx;
        cmd.step_delay  <= c.delay;
        cmd.sound_id    <= c.snd;
        cmd.delta_time  <= c.delta;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
    endtask

    function automatic cue_cmd_t mk(input logic [tcsp_pkg::OP_W-1:0] op, input int id,
                                    input int cnt, input int idx, input logic [31:0] delay,
                                    input int snd, input logic [31:0] delta);
        cue_cmd_t c;
        c.op = op;
        c.id = 4'(id);
        c.cnt = 4'(cnt);
        c.idx = 3'(idx);
        c.delay = delay;
        c.snd = 16'(snd);
        c.delta = delta;
        c.typed = 1'b0;
        c.typed_status = tcsp_pkg::ST_OK;
        return c;
    endfunction

    function automatic cue_cmd_t typed(input cue_cmd_t c,
                                       input logic [tcsp_pkg::STATUS_W-1:0] st);
        c.typed = 1'b1;
        c.typed_status = st;
        return c;
    endfunction

    // fill every step of a sequence so that a trigger never reads an unwritten step
    task automatic load_sequence(input int id, input int len, input bit big);
        for (int k = 0; k < N_STEPS; k++)
            send_cue(mk(tcsp_pkg::OP_WRITE, id, 0, k,
                        big ? 32'({$urandom(), 16'h0} >> $urandom_range(31))
                            : 32'($urandom_range(8)) << 16,
                        ($urandom_range(5) == 0) ? 0 : $urandom_range(65535), $urandom()));
        send_cue(mk(tcsp_pkg::OP_DEFINE, id, len, $urandom_range(7), $urandom(),
                    $urandom(), $urandom()));
    endtask

    // rsp sink: random stalls, compare with the oldest expectation
    always @(posedge clk)
    begin
        cue_rsp_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                    report("response item with nothing expected");
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.kind !== want.kind || rsp.status !== want.status ||
                        rsp.played_sound !== want.sound || rsp.last !== want.last)
                        report($sformatf("got k%0b s%0d snd%h l%0b, want k%0b s%0d snd%h l%0b",
                                         rsp.kind, rsp.status, rsp.played_sound, rsp.last,
                                         want.kind, want.status, want.sound, want.last));
                end
            end
            rsp.ready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    cue_cmd_t directed[$];
    cue_cmd_t c;
    int op_pick, len, nsent;
    bit ok_ids[N_SEQ];

    initial
    begin
        errors = 0;
        quiet = 1'b0;
        act_count = 0;
        foreach (seq_defined[i]) seq_defined[i] = 1'b0;
        foreach (seq_len[i]) seq_len[i] = '0;
        foreach (step_time[i]) step_time[i] = '0;
        foreach (step_sound[i]) step_sound[i] = '0;
        cmd.valid <= 1'b0;
        cmd.operation <= tcsp_pkg::OP_CLEAR;
        cmd.sequence_id <= '0;
        cmd.step_count <= '0;
        cmd.step_index <= '0;
        cmd.step_delay <= '0;
        cmd.sound_id <= '0;
        cmd.delta_time <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: rejects, extremes, undefined trigger, zero sound, overflow of step count
        directed = {directed, typed(mk(tcsp_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h7FFF_FFFF),
                                    tcsp_pkg::ST_OK)};
        directed = {directed, typed(mk(tcsp_pkg::OP_TRIGGER, 5, 0, 0, 0, 0, 0),
                                    tcsp_pkg::ST_REJECT)};
        directed = {directed, typed(mk(tcsp_pkg::OP_DEFINE, 0, 3, 0, 0, 0, 0),
                                    tcsp_pkg::ST_REJECT)};
        directed = {directed, typed(mk(tcsp_pkg::OP_WRITE, 0, 0, 0, 0, 1, 0),
                                    tcsp_pkg::ST_REJECT)};
        directed = {directed, typed(mk(tcsp_pkg::OP_TRIGGER, 0, 0, 0, 0, 0, 0),
                                    tcsp_pkg::ST_REJECT)};
        directed = {directed, typed(mk(3'd5, 3, 0, 0, 0, 0, 0), tcsp_pkg::ST_REJECT)};
        directed = {directed, typed(mk(3'd7, 15, 15, 7, '1, 16'hFFFF, '1),
                                    tcsp_pkg::ST_REJECT)};
        for (int k = 0; k < N_STEPS; k++)
            directed = {directed, mk(tcsp_pkg::OP_WRITE, 15, 0, k,
                                     (k == 7) ? 32'hFFFF_FFFF : k << 16,
                                     (k == 2) ? 0 : ((k == 7) ? 16'hFFFF : k + 1), 0)};
        directed = {directed, typed(mk(tcsp_pkg::OP_DEFINE, 15, 15, 0, 0, 0, 0),
                                    tcsp_pkg::ST_OK)};
        directed = {directed, typed(mk(tcsp_pkg::OP_TRIGGER, 15, 0, 0, 0, 0, 0),
                                    tcsp_pkg::ST_OK)};
        directed = {directed, mk(tcsp_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h8000_0000)};
        directed = {directed, mk(tcsp_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h0002_8000)};
        directed = {directed, mk(tcsp_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h7FFF_FFFF)};
        directed = {directed, mk(tcsp_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h7FFF_FFFF)};
        directed = {directed, mk(tcsp_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h7FFF_FFFF)};
        directed = {directed, typed(mk(tcsp_pkg::OP_DEFINE, 15, 0, 0, 0, 0, 0),
                                    tcsp_pkg::ST_OK)};
        directed = {directed, typed(mk(tcsp_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0),
                                    tcsp_pkg::ST_OK)};
        foreach (directed[i]) send_cue(directed[i]);

        // fill the active list to the brim for the full status
        for (int k = 0; k <= N_ACTIVE; k++)
            send_cue(typed(mk(tcsp_pkg::OP_TRIGGER, 15, 0, 0, 0, 0, 0),
                           (k == N_ACTIVE) ? tcsp_pkg::ST_FULL : tcsp_pkg::ST_OK));
        send_cue(mk(tcsp_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));

        // hold off until every expected item has drained
        cmd.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        foreach (ok_ids[i]) ok_ids[i] = 1'b0;
        nsent = 0;
        while (nsent < 350)
        begin
            quiet = (nsent >= 120 && nsent < 180);
            op_pick = $urandom_range(99);
            if (op_pick < 8)
            begin
                c.id = 4'($urandom_range(1, 15));
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
                load_sequence(c.id, len, $urandom_range(3) == 0);
                ok_ids[c.id] = 1'b1;
                nsent += N_STEPS + 1;
            end
            else
            begin
                c = mk(3'($urandom_range(7)), $urandom_range(15),
                       $urandom_range(15), $urandom_range(7), $urandom(),
                       $urandom_range(65535), $urandom());
                if (op_pick < 40) c.op = tcsp_pkg::OP_TRIGGER;
                else if (op_pick < 75)
                begin
                    c.op = tcsp_pkg::OP_TICK;
                    if ($urandom_range(3) != 0) c.delta = $urandom_range(3 << 16);
                end
                else if (op_pick < 80) c.op = tcsp_pkg::OP_CLEAR;
                else if (op_pick < 88) c.op = 3'($urandom_range(5, 7));
                // keep clear of unwritten steps: only redefine fully loaded ids, id 0 is a reject
                if (c.op == tcsp_pkg::OP_DEFINE && c.id != 0 && !ok_ids[c.id])
                    c.op = tcsp_pkg::OP_TRIGGER;
                if (c.op == tcsp_pkg::OP_TRIGGER && c.id != 0 && seq_defined[c.id]
                    && !ok_ids[c.id])
                    c.id = '0;
                if (c.op == tcsp_pkg::OP_WRITE && c.id != 0 && !ok_ids[c.id]
                    && seq_defined[c.id]) c.id = '0;
                send_cue(c);
                nsent++;
            end
        end
        quiet = 1'b0;

        cmd.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
